>>> design/work_stealing_deque_defines.svh
// ----------------------------------------------------------------------------
// work_stealing_deque_defines : assertion macros
// shared concurrent assertion forms for the deque checker
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_DEQUE_DEFINES_SVH
`define WORK_STEALING_DEQUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSD_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("deque check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off during reset
`define WSD_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("deque check failed: next-cycle rule");

`endif

>>> design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// operation and status codes and the command word broadcast to the cell row
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam int TASK_W = 64;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_STEAL = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic              push_shift;  // shift toward far end, new word into cell 0
        logic              pop_shift;   // shift toward cell 0
        logic              launch;      // oldest cell copies its word into the return lane
        logic [TASK_W-1:0] task_word;   // word entering cell 0 on a push
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/work_stealing_deque.sv
// push, pop, empty and full results: registered, out_valid in the cycle after accept,
//   one word per cycle while the result side keeps taking words
// steal with n words held: the result waits for the return lane, walking one cell
//   per cycle from cell n-1 down to cell 0, to bring the word to cell 0; no accept meanwhile
// rst_n is asynchronous, active low: internal occupancy count zero, no result pending;
//   the cell row itself is not cleared, its words count only below occupancy
`default_nettype none

// ----------------------------------------------------------------------------
// work_stealing_deque
// bounded double-ended task store built as a row of identical cells
// ----------------------------------------------------------------------------
//
// organization
//   cell 0 holds the newest word (bottom end), cell occupancy-1 the oldest
//   (top end). occupancy lives in the controller; cells above it hold stale
//   words that are never read.
//
//   push  : every cell takes its lower neighbor, cell 0 takes task_in
//   pop   : cell 0 is the result, every cell takes its upper neighbor
//   steal : the oldest cell copies its word into a return lane that shifts
//           toward cell 0 each cycle; the controller counts the hops and
//           takes the word from the lane at cell 0
//
// a push into a full row is dropped with status full; pop or steal on an
// empty row reports status empty with a zero word; an unused operation code
// changes nothing and reports ok
//
module work_stealing_deque #(
    parameter int DEPTH = 1024
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // input words
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [wsd_pkg::FUNC_W-1:0]         func,
    input  wire  [wsd_pkg::TASK_W-1:0]         task_in,
    // result words
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [wsd_pkg::STAT_W-1:0]         status,
    output logic [wsd_pkg::TASK_W-1:0]         task_out,
    output logic [$clog2(DEPTH+1)-1:0]         occupancy
);

    import wsd_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);

    // broadcast command and the slot that launches on a steal
    cell_cmd_t         cmd;
    logic [SLOT_W-1:0] launch_slot;

    // per-cell word and return-lane outputs
    logic [TASK_W-1:0] cell_data [DEPTH];
    logic [TASK_W-1:0] cell_lane [DEPTH];

    wsd_ctrl #(
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W),
        .OCC_W  (OCC_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .task_in     (task_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .task_out    (task_out),
        .occupancy   (occupancy),
        .cmd         (cmd),
        .launch_slot (launch_slot),
        .head_data   (cell_data[0]),
        .head_lane   (cell_lane[0])
    );

    // the cell row; the ends take task_in and zeros for their missing neighbors
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [TASK_W-1:0] prev_w;
        logic [TASK_W-1:0] next_w;
        logic [TASK_W-1:0] next_lane_w;

        if (g == 0)
        begin : g_first
            assign prev_w = cmd.task_word;
        end
        else
        begin : g_mid_lo
            assign prev_w = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_w      = '0;
            assign next_lane_w = '0;
        end
        else
        begin : g_mid_hi
            assign next_w      = cell_data[g+1];
            assign next_lane_w = cell_lane[g+1];
        end

        wsd_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .launch_slot (launch_slot),
            .prev_data   (prev_w),
            .next_data   (next_w),
            .next_lane   (next_lane_w),
            .data        (cell_data[g]),
            .lane        (cell_lane[g])
        );
    end

endmodule

`default_nettype wire

>>> design/wsd_cell.sv
// ----------------------------------------------------------------------------
// wsd_cell
// one slot of the deque row: a held word and one stage of the return lane
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_cell #(
    parameter int SLOT_W = 10,
    parameter int INDEX  = 0
) (
    input  wire                       clk,
    input  wsd_pkg::cell_cmd_t        cmd,
    input  wire  [SLOT_W-1:0]         launch_slot,
    input  wire  [wsd_pkg::TASK_W-1:0] prev_data,
    input  wire  [wsd_pkg::TASK_W-1:0] next_data,
    input  wire  [wsd_pkg::TASK_W-1:0] next_lane,
    output logic [wsd_pkg::TASK_W-1:0] data,
    output logic [wsd_pkg::TASK_W-1:0] lane
);

    import wsd_pkg::*;

    logic [TASK_W-1:0] data_reg;
    logic [TASK_W-1:0] data_next;
    logic [TASK_W-1:0] lane_reg;
    logic [TASK_W-1:0] lane_next;
    logic              is_launch;

    assign is_launch = cmd.launch && (launch_slot == SLOT_W'(INDEX));

    always_comb
    begin
        if (cmd.push_shift)
        begin
            data_next = prev_data;
        end
        else if (cmd.pop_shift)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // lane moves one cell toward the bottom end every cycle
    assign lane_next = is_launch ? data_reg : next_lane;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        lane_reg <= lane_next;
    end

    assign data = data_reg;
    assign lane = lane_reg;

endmodule

`default_nettype wire

>>> design/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// occupancy count, handshakes, steal countdown and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_ctrl #(
    parameter int DEPTH  = 1024,
    parameter int SLOT_W = 10,
    parameter int OCC_W  = 11
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  [wsd_pkg::FUNC_W-1:0] func,
    input  wire  [wsd_pkg::TASK_W-1:0] task_in,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic [wsd_pkg::STAT_W-1:0] status,
    output logic [wsd_pkg::TASK_W-1:0] task_out,
    output logic [OCC_W-1:0]           occupancy,
    output wsd_pkg::cell_cmd_t         cmd,
    output logic [SLOT_W-1:0]          launch_slot,
    input  wire  [wsd_pkg::TASK_W-1:0] head_data,
    input  wire  [wsd_pkg::TASK_W-1:0] head_lane
);

    import wsd_pkg::*;

    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [TASK_W-1:0] task_reg;
    logic [TASK_W-1:0] task_next;
    logic [OCC_W-1:0]  occ_out_reg;
    logic [OCC_W-1:0]  occ_out_next;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic [OCC_W-1:0]  occ_dec;

    assign in_stall = busy_reg || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == OCC_W'(DEPTH));
    assign occ_dec  = occ_reg - OCC_W'(1);

    // oldest word sits in cell occupancy-1
    assign launch_slot = occ_dec[SLOT_W-1:0];

    always_comb
    begin
        occ_next       = occ_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        task_next      = task_reg;
        occ_out_next   = occ_out_reg;
        cmd.push_shift = 1'b0;
        cmd.pop_shift  = 1'b0;
        cmd.launch     = 1'b0;
        cmd.task_word  = task_in;

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            task_next      = '0;
            occ_out_next   = occ_reg;
            case (func)
                FN_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.push_shift = 1'b1;
                        occ_next       = occ_reg + OCC_W'(1);
                        occ_out_next   = occ_reg + OCC_W'(1);
                    end
                end
                FN_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_shift = 1'b1;
                        task_next     = head_data;
                        occ_next      = occ_dec;
                        occ_out_next  = occ_dec;
                    end
                end
                FN_STEAL:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        // result waits until the word reaches cell 0
                        cmd.launch     = 1'b1;
                        occ_next       = occ_dec;
                        busy_next      = 1'b1;
                        cnt_next       = occ_dec[SLOT_W-1:0];
                        out_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                task_next      = head_lane;
                occ_out_next   = occ_reg;
            end
            else
            begin
                cnt_next = cnt_reg - SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        task_reg    <= task_next;
        occ_out_reg <= occ_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign task_out  = task_reg;
    assign occupancy = occ_out_reg;

endmodule

`default_nettype wire

>>> design/wsd_check.sv
// ----------------------------------------------------------------------------
// wsd_check
// port-level checks on the deque result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "work_stealing_deque_defines.svh"

module wsd_check #(
    parameter int DEPTH = 1024
) (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_stall,
    input wire                         out_valid,
    input wire                         out_stall,
    input wire [wsd_pkg::STAT_W-1:0]   status,
    input wire [wsd_pkg::TASK_W-1:0]   task_out,
    input wire [$clog2(DEPTH+1)-1:0]   occupancy
);

    import wsd_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    // a held result word stays offered
    `WSD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(task_out))

    // a held result word keeps the input side stalled
    `WSD_ASSERT_IMP(a_in_hold, out_valid && out_stall, in_stall)

    // anything but a successful take carries a zero word
    `WSD_ASSERT_IMP(a_zero_word, out_valid && status != ST_OK, task_out == '0)

    // a dropped push only happens with the row full
    `WSD_ASSERT_IMP(a_full_occ, out_valid && status == ST_FULL, occupancy == OCC_W'(DEPTH))

    // an empty report leaves nothing held
    `WSD_ASSERT_IMP(a_empty_occ, out_valid && status == ST_EMPTY, occupancy == '0)

endmodule

bind work_stealing_deque wsd_check #(
    .DEPTH (DEPTH)
) u_wsd_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .task_out  (task_out),
    .occupancy (occupancy)
);

`default_nettype wire

>>> test/wsd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsd_checker
// watches both channels of the work stealing deque, keeps a ring model of
// the task store, and compares every result word field by field
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_checker #(
    parameter int DEPTH = 1024,
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    input  wire                         in_stall,
    input  wire  [wsd_pkg::FUNC_W-1:0]  func,
    input  wire  [wsd_pkg::TASK_W-1:0]  task_in,
    input  wire                         out_valid,
    input  wire                         out_stall,
    input  wire  [wsd_pkg::STAT_W-1:0]  status,
    input  wire  [wsd_pkg::TASK_W-1:0]  task_out,
    input  wire  [OCC_W-1:0]            occupancy,
    output int                          fail_count,
    output int                          pending
);

    import wsd_pkg::*;

    localparam int SPAN = 2 * DEPTH;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [TASK_W-1:0] word;
        logic [OCC_W-1:0]  count;
    } deque_result_t;

    logic [TASK_W-1:0] ring [DEPTH];
    int                top_i = 0;
    int                bottom_i = 0;
    int                n_fail = 0;
    int                n_pending = 0;
    deque_result_t     expected_q [$];
    deque_result_t     oldest;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    // one operation on the ring model, returns the result word it yields
    function automatic deque_result_t apply_op(input logic [FUNC_W-1:0] op,
                                               input logic [TASK_W-1:0] word);
        deque_result_t r;
        int            held_n;
        int            last_i;
        begin
            held_n   = (bottom_i + SPAN - top_i) % SPAN;
            r.status = ST_OK;
            r.word   = '0;
            case (op)
                FN_PUSH:
                begin
                    if (held_n >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        ring[bottom_i % DEPTH] = word;
                        bottom_i = (bottom_i + 1) % SPAN;
                    end
                end
                FN_POP:
                begin
                    if (held_n == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        last_i = (bottom_i + SPAN - 1) % SPAN;
                        r.word = ring[last_i % DEPTH];
                        // last word: top moves up and bottom follows it
                        if (held_n == 1)
                        begin
                            top_i    = (top_i + 1) % SPAN;
                            bottom_i = top_i;
                        end
                        else
                            bottom_i = last_i;
                    end
                end
                FN_STEAL:
                begin
                    if (held_n == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.word = ring[top_i % DEPTH];
                        top_i  = (top_i + 1) % SPAN;
                    end
                end
                default:
                    ;
            endcase
            held_n  = (bottom_i + SPAN - top_i) % SPAN;
            r.count = held_n[OCC_W-1:0];
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_i    = 0;
            bottom_i = 0;
            expected_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing outstanding");
                    n_fail++;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        n_fail++;
                    end
                    if (task_out !== oldest.word)
                    begin
                        $error("task_out: expected %h, got %h", oldest.word, task_out);
                        n_fail++;
                    end
                    if (occupancy !== oldest.count)
                    begin
                        $error("occupancy: expected %0d, got %0d", oldest.count, occupancy);
                        n_fail++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(apply_op(func, task_in));
        end
        n_pending = expected_q.size();
    end

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives push, pop, steal and spare operation words into the deque with
// random gaps and result-side stalls; a checker beside the block predicts
// and compares every result word, this module gives the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import wsd_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    // a steal from a full row walks the whole row; leave room for long stalls
    localparam int QUIET_LIMIT = 20000;
    // spare operation code, the block treats it as a no-op
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_in;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] task_out;
    logic [OCC_W-1:0]  occupancy;

    int fail_count;
    int pending;
    int fill = 0;       // words held, tracked only to steer the stimulus
    int quiet_run = 0;
    bit steady = 1'b0;  // when set neither side idles

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    work_stealing_deque #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .task_in   (task_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .task_out  (task_out),
        .occupancy (occupancy)
    );

    wsd_checker #(
        .DEPTH (DEPTH)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .task_in    (task_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .task_out   (task_out),
        .occupancy  (occupancy),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side: stall with a chance of about 29 in a hundred unless steady
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 29);

    // watchdog: too many cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_run <= 0;
        else if (quiet_run >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_run <= quiet_run + 1;
    end

    // weighted operation pick, whatever is left of a hundred goes to the spare code
    function automatic logic [FUNC_W-1:0] pick_func(input int w_push, input int w_pop,
                                                    input int w_steal);
        int r;
        begin
            r = $urandom_range(99);
            if (r < w_push)
                return FN_PUSH;
            else if (r < w_push + w_pop)
                return FN_POP;
            else if (r < w_push + w_pop + w_steal)
                return FN_STEAL;
            else
                return FN_SPARE;
        end
    endfunction

    // mostly random task words, with all-zero and all-one words now and then
    function automatic logic [TASK_W-1:0] random_word();
        begin
            case ($urandom_range(7))
                0:       return '0;
                1:       return '1;
                default: return {$urandom(), $urandom()};
            endcase
        end
    endfunction

    // present one input word, hold it until taken, called at a falling edge
    task automatic offer_word(input logic [FUNC_W-1:0] f, input logic [TASK_W-1:0] t);
        begin
            // random gaps before the word
            while (!steady && $urandom_range(99) < 29)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            func     <= f;
            task_in  <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            // keep the word count used for steering in step with the block
            if (f == FN_PUSH && fill < DEPTH)
                fill++;
            else if ((f == FN_POP || f == FN_STEAL) && fill > 0)
                fill--;
            @(negedge clk);
        end
    endtask

    // hold the input side until every outstanding result word has come back
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (pending != 0)
                @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FN_PUSH;
        task_in  = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty row, extreme words, pop and steal of the last word
        offer_word(FN_STEAL, '1);
        offer_word(FN_POP, '1);
        offer_word(FN_SPARE, '1);
        offer_word(FN_PUSH, '1);
        offer_word(FN_PUSH, '0);
        offer_word(FN_POP, '0);
        offer_word(FN_STEAL, '0);
        offer_word(FN_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
        offer_word(FN_POP, '0);
        offer_word(FN_STEAL, '1);
        offer_word(FN_PUSH, 64'h5555_5555_5555_5555);
        offer_word(FN_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
        offer_word(FN_PUSH, 64'h8000_0000_0000_0001);
        offer_word(FN_SPARE, '0);
        offer_word(FN_STEAL, '0);
        offer_word(FN_STEAL, '0);
        offer_word(FN_STEAL, '0);
        offer_word(FN_POP, '0);
        offer_word(FN_PUSH, 64'h0123_4567_89ab_cdef);
        offer_word(FN_SPARE, '1);
        offer_word(FN_POP, '0);

        // sender pause with the row idle
        wait_drained();

        // low occupancy mix, with a stretch where neither side idles
        for (int i = 0; i < 120; i++)
        begin
            steady = (i >= 30 && i < 100);
            if (fill < 20)
                offer_word(pick_func(45, 22, 23), random_word());
            else
                offer_word(pick_func(15, 40, 40), random_word());
        end
        steady = 1'b0;

        // fill the row, steals stay rare since they walk the whole row
        while (fill < DEPTH)
            offer_word(pick_func(96, 2, 1), random_word());

        // around full: dropped pushes, steals of the oldest word from a full row
        for (int i = 0; i < 40; i++)
            offer_word(pick_func(60, 15, 15), random_word());

        wait_drained();

        // drain part of the row, mostly through pops
        for (int i = 0; i < 150; i++)
            offer_word(pick_func(8, 86, 3), random_word());

        // wait for the last result words, then let the clock run on quietly before the verdict
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+design
design/wsd_pkg.sv
design/wsd_cell.sv
design/wsd_ctrl.sv
design/work_stealing_deque.sv
design/wsd_check.sv
test/wsd_checker.sv
test/testbench.sv
